// ----- src/sdff_pkg.sv -----
// Shared types, constants and ASCII codes for the signed decimal field formatter.
`timescale 1ns / 1ps

package sdff_pkg;

   // Field limit and derived widths
   localparam int MAX_FIELD = 63;
   localparam int FIELD_W   = $clog2(MAX_FIELD + 1);
   localparam int CLAMP_W   = 9;

   // Binary to BCD conversion
   localparam int MAG_W      = 64;
   localparam int DIGITS     = 20;
   localparam int BCD_W      = 4 * DIGITS;
   localparam int STEP_BITS  = 4;
   localparam int STEPS      = MAG_W / STEP_BITS;
   localparam int STEP_CNT_W = $clog2(STEPS);
   localparam int NDIG_W     = $clog2(DIGITS + 1);
   localparam int DIG_IDX_W  = $clog2(DIGITS);

   // Port widths
   localparam int TOTAL_W = 32;
   localparam int REQ_W   = 88;
   localparam int RSP_W   = 40;

   // Length codes
   localparam logic [2:0] LEN_INT32 = 3'd0;
   localparam logic [2:0] LEN_INT8  = 3'd1;
   localparam logic [2:0] LEN_INT16 = 3'd2;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_LAYOUT,
      ST_EMIT
   } state_type;

   // Conversion unit status
   typedef struct packed {
      logic busy;
      logic done;
   } bcd_status_type;

   // Field layout handed to the character emitter
   typedef struct packed {
      logic [FIELD_W-1:0] m;
      logic [FIELD_W-1:0] pad;
      logic [FIELD_W-1:0] nad;
      logic [FIELD_W-1:0] dstart;
      logic [FIELD_W-1:0] dend;
      logic [NDIG_W-1:0]  ndig;
      logic               ad;
      logic               left;
      logic               zfill;
      logic [7:0]         sign_char;
   } layout_type;

endpackage

// ----- src/sdff_bcd_unit.sv -----
// Iterative binary to BCD converter, shift-and-add-3, four bits per cycle.
`timescale 1ns / 1ps

module sdff_bcd_unit
   import sdff_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MAG_W-1:0]     mag,
   output bcd_status_type       status,
   output logic [BCD_W-1:0]     digits,
   output logic [NDIG_W-1:0]    ndig
);

   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [MAG_W-1:0]      bin_ff, bin_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic [BCD_W-1:0]      bcd_step;
   logic [MAG_W-1:0]      bin_step;
   logic                  last_step;

   // One step: four rounds of digit adjust then shift
   always_comb begin
      logic [BCD_W-1:0] b;
      logic [MAG_W-1:0] r;
      b = bcd_ff;
      r = bin_ff;
      for (int s = 0; s < STEP_BITS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (b[4*d +: 4] >= 4'd5) begin
               b[4*d +: 4] = b[4*d +: 4] + 4'd3;
            end
         end
         b = {b[BCD_W-2:0], r[MAG_W-1]};
         r = {r[MAG_W-2:0], 1'b0};
      end
      bcd_step = b;
      bin_step = r;
   end

   assign last_step = busy_ff && (cnt_ff == STEP_CNT_W'(STEPS - 1));

   // Sequencing
   always_comb begin
      bcd_in  = bcd_ff;
      bin_in  = bin_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         bcd_in  = '0;
         bin_in  = mag;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in  = bcd_step;
         bin_in  = bin_step;
         cnt_in  = cnt_ff + 1'b1;
         busy_in = !last_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   // Significant digit count: highest nonzero digit
   always_comb begin
      ndig = '0;
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] != 4'd0) begin
            ndig = NDIG_W'(d + 1);
         end
      end
   end

   assign digits      = bcd_ff;
   assign status.busy = busy_ff;
   assign status.done = last_step;

endmodule

// ----- src/sdff_emitter.sv -----
// Character emitter: walks the field one position per item and holds the output register.
`timescale 1ns / 1ps

module sdff_emitter
   import sdff_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               active,
   input  layout_type         layout,
   input  logic [BCD_W-1:0]   digits,
   output logic               emit_done,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,
   output logic               rsp_tlast
);

   logic [FIELD_W-1:0] pos_ff, pos_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               valid_ff, valid_in;
   logic [7:0]         char_ff, char_in;
   logic               last_ff, last_in;
   logic               load;
   logic               is_last;
   logic [FIELD_W-1:0] k;
   logic [DIG_IDX_W-1:0] k_idx;
   logic [7:0]         digit_char;

   assign load    = active && (!valid_ff || rsp_tready);
   assign is_last = (pos_ff == layout.m - 1'b1);

   // Digit at this position, counted from the least significant
   assign k     = layout.dend - pos_ff;
   assign k_idx = k[DIG_IDX_W-1:0];
   always_comb begin
      digit_char = CHAR_ZERO;
      if (k < FIELD_W'(layout.ndig)) begin
         digit_char = CHAR_ZERO | {4'd0, digits[4*k_idx +: 4]};
      end
   end

   // Character select by region
   always_comb begin
      char_in = char_ff;
      if (layout.left) begin
         if (pos_ff < FIELD_W'(layout.ad)) char_in = layout.sign_char;
         else if (pos_ff < layout.nad)     char_in = digit_char;
         else                              char_in = CHAR_SPACE;
      end else if (layout.zfill) begin
         if (pos_ff < FIELD_W'(layout.ad)) char_in = layout.sign_char;
         else if (pos_ff < layout.dstart)  char_in = CHAR_ZERO;
         else                              char_in = digit_char;
      end else begin
         if (pos_ff < layout.pad)          char_in = CHAR_SPACE;
         else if (pos_ff < layout.dstart)  char_in = layout.sign_char;
         else                              char_in = digit_char;
      end
   end

   // Output register and counters
   always_comb begin
      pos_in   = pos_ff;
      total_in = total_ff;
      valid_in = valid_ff && !rsp_tready;
      last_in  = last_ff;
      if (load) begin
         pos_in   = is_last ? '0 : pos_ff + 1'b1;
         total_in = total_ff + 1'b1;
         valid_in = 1'b1;
         last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
      if (load) begin
         char_ff <= char_in;
      end
      last_ff <= last_in;
   end

   assign emit_done  = load && is_last;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {total_ff, char_ff};
   assign rsp_tlast  = last_ff;

endmodule

// ----- src/signed_decimal_field_formatter.sv -----
// Top level: spec capture, conversion sequencer and field layout for signed decimal text.
`timescale 1ns / 1ps
//
// Formats one signed integer per input item as printf-style decimal text.
// Input channel req_*: one item carries the value and its conversion spec.
// Result channel rsp_*: one item per character, rsp_tlast on the final one,
// with the running count of characters emitted since reset.
// Flow: the item is taken in IDLE; the shared shift-and-add-3 unit then
// converts four magnitude bits per cycle over 64 bits, the LAYOUT state
// builds the field layout, and the field is sent at one character per cycle
// while the receiver is ready. The field length m runs from 0 to 63;
// req_tready is high only while idle.
// An empty field (zero, precision zero, no sign, width zero) yields no items.
// Reset clears the sequencer, the output valid flag and the character count.
// When the receiver stalls, the output register holds its character and the
// emitter waits; the next input item may be taken once the last character
// of the field has entered the output register.
//
module signed_decimal_field_formatter
   import sdff_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // value[63:0], length_mode[66:64], min_width[72:67], precision_given[73],
   // precision[79:74], left_justify[80], zero_pad[81], plus_sign[82],
   // space_sign[83], zeros[87:84]
   input  logic [REQ_W-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // out_char[7:0], total_chars[39:8]
   output logic [RSP_W-1:0]   rsp_tdata,
   output logic               rsp_tlast
);

   typedef struct packed {
      logic [FIELD_W-1:0] prec;
      logic [FIELD_W-1:0] width;
      logic               pgiven;
      logic               left;
      logic               zflag;
      logic               plus;
      logic               space;
      logic               neg;
   } spec_type;

   state_type          state_ff, state_in;
   spec_type           spec_ff, spec_in;
   layout_type         layout_ff, layout_in;
   logic               accept;
   logic [MAG_W-1:0]   value;
   logic [2:0]         length_mode;
   logic [5:0]         min_width;
   logic [5:0]         precision;
   logic [MAG_W-1:0]   trunc;
   logic [MAG_W-1:0]   mag;
   logic [CLAMP_W-1:0] prec_wide;
   logic [CLAMP_W-1:0] width_wide;
   bcd_status_type     bcd_status;
   logic [BCD_W-1:0]   digits;
   logic [NDIG_W-1:0]  ndig;
   logic               emit_done;
   logic [FIELD_W-1:0] n;

   assign value       = req_tdata[63:0];
   assign length_mode = req_tdata[66:64];
   assign min_width   = req_tdata[72:67];
   assign precision   = req_tdata[79:74];
   assign accept      = req_tvalid && req_tready;
   assign req_tready  = (state_ff == ST_IDLE);

   // Length truncation with sign extension, then magnitude
   always_comb begin
      case (length_mode)
         LEN_INT32: trunc = {{32{value[31]}}, value[31:0]};
         LEN_INT8:  trunc = {{56{value[7]}}, value[7:0]};
         LEN_INT16: trunc = {{48{value[15]}}, value[15:0]};
         default:   trunc = value;
      endcase
      mag = trunc[MAG_W-1] ? (~trunc + 1'b1) : trunc;
   end

   // Spec capture with saturation
   assign prec_wide  = CLAMP_W'(precision);
   assign width_wide = CLAMP_W'(min_width);
   always_comb begin
      spec_in = spec_ff;
      if (accept) begin
         spec_in.pgiven = req_tdata[73];
         spec_in.left   = req_tdata[80];
         spec_in.zflag  = req_tdata[81];
         spec_in.plus   = req_tdata[82];
         spec_in.space  = req_tdata[83];
         spec_in.neg    = trunc[MAG_W-1];
         if (!req_tdata[73]) begin
            spec_in.prec = FIELD_W'(1);
         end else if (prec_wide > CLAMP_W'(MAX_FIELD - 1)) begin
            spec_in.prec = FIELD_W'(MAX_FIELD - 1);
         end else begin
            spec_in.prec = FIELD_W'(prec_wide);
         end
         if (width_wide > CLAMP_W'(MAX_FIELD)) begin
            spec_in.width = FIELD_W'(MAX_FIELD);
         end else begin
            spec_in.width = FIELD_W'(width_wide);
         end
      end
   end

   sdff_bcd_unit u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .mag    (mag),
      .status (bcd_status),
      .digits (digits),
      .ndig   (ndig)
   );

   // Field layout from digit count and spec
   assign n = (FIELD_W'(ndig) > spec_ff.prec) ? FIELD_W'(ndig) : spec_ff.prec;
   always_comb begin
      layout_in           = layout_ff;
      layout_in.ndig      = ndig;
      layout_in.ad        = spec_ff.neg || spec_ff.plus || spec_ff.space;
      layout_in.nad       = n + FIELD_W'(layout_in.ad);
      layout_in.m         = (layout_in.nad > spec_ff.width) ? layout_in.nad : spec_ff.width;
      layout_in.pad       = layout_in.m - layout_in.nad;
      layout_in.left      = spec_ff.left;
      layout_in.zfill     = spec_ff.zflag && !spec_ff.left && !spec_ff.pgiven;
      layout_in.dstart    = spec_ff.left ? FIELD_W'(layout_in.ad)
                                         : FIELD_W'(layout_in.ad) + layout_in.pad;
      layout_in.dend      = layout_in.dstart + n - 1'b1;
      layout_in.sign_char = spec_ff.neg ? CHAR_MINUS : (spec_ff.plus ? CHAR_PLUS : CHAR_SPACE);
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (bcd_status.done) state_in = ST_LAYOUT;
         end
         ST_LAYOUT: begin
            state_in = (layout_in.m != '0) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (emit_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      spec_ff <= spec_in;
      if (state_ff == ST_LAYOUT) begin
         layout_ff <= layout_in;
      end
   end

   sdff_emitter u_emit (
      .clock      (clock),
      .reset      (reset),
      .active     (state_ff == ST_EMIT),
      .layout     (layout_ff),
      .digits     (digits),
      .emit_done  (emit_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Checks
   a_conv_only_busy: assert property (@(posedge clock) disable iff (reset)
      bcd_status.busy |-> (state_ff == ST_CONV))
      else $error("conversion unit busy outside conversion");

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CONV) && bcd_status.busy)
      else $error("accepted item did not start conversion");

   a_emit_field_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (layout_ff.m != '0) &&
                                (FIELD_W'(layout_ff.ndig) <= layout_ff.m))
      else $error("field length inconsistent during emission");

   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAYOUT) |-> (ndig <= NDIG_W'(DIGITS)))
      else $error("digit count out of range");

endmodule

// ----- tb/tb_signed_decimal_field_formatter.sv -----
// Self-checking testbench for the signed decimal field formatter.
`timescale 1ns / 1ps
//
// Items of value plus conversion spec go in on req_*, and every character
// that comes out on rsp_* is checked against a field predicted in the bench.
// A short directed list covers the extremes, every length code and the
// special layouts. A random list of about 500 items follows. Idling is
// random on both sides until a final idle-free phase, and one long receiver stall backs the block up.
//
module tb_signed_decimal_field_formatter;
   import sdff_pkg::*;

   // int64 length codes; 5 to 7 also act as int64
   localparam logic [2:0] LEN_LONG   = 3'd3;
   localparam logic [2:0] LEN_LLONG  = 3'd4;
   localparam logic [2:0] LEN_SPARE  = 3'd7;
   localparam int RANDOM_FIELDS      = 500;
   localparam int PHASE_ONE_END      = 180;
   localparam int PHASE_TWO_END      = 360;
   localparam int STALL_AT_FIELD     = 100;
   localparam int STALL_CYCLES       = 400;
   localparam int DRAIN_CYCLES       = 40;
   localparam int WATCHDOG_LIMIT     = 2000;
   localparam int MAX_PRINTED        = 40;

   typedef struct {
      logic [63:0] value;
      logic [2:0]  length_mode;
      logic [5:0]  min_width;
      logic        precision_given;
      logic [5:0]  precision;
      logic        left_justify;
      logic        zero_pad;
      logic        plus_sign;
      logic        space_sign;
   } field_spec_type;

   typedef struct {
      logic [7:0]         symbol;
      logic               is_last;
      logic [TOTAL_W-1:0] running_total;
   } field_char_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   field_spec_type pending_specs[$];
   field_spec_type offered_spec;
   field_char_type expected_chars[$];
   field_char_type oldest_char;
   logic [TOTAL_W-1:0] chars_emitted = '0;

   int fields_accepted = 0;
   int chars_checked   = 0;
   int empty_fields    = 0;
   int error_count     = 0;
   int quiet_cycles    = 0;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_left      = 0;
   bit stall_done      = 1'b0;

   signed_decimal_field_formatter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string what);
      if (error_count < MAX_PRINTED)
         $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   function automatic field_spec_type make_spec(logic [63:0] value, logic [2:0] len, int width,
                                                bit pg, int prec, bit lj, bit zp, bit ps,
                                                bit ss);
      field_spec_type s;
      s.value           = value;
      s.length_mode     = len;
      s.min_width       = 6'(width);
      s.precision_given = pg;
      s.precision       = 6'(prec);
      s.left_justify    = lj;
      s.zero_pad        = zp;
      s.plus_sign       = ps;
      s.space_sign      = ss;
      return s;
   endfunction

   // Lay out one field and queue its characters with the running count
   function automatic void format_field(field_spec_type s);
      logic [63:0] v;
      logic [63:0] mag;
      logic [3:0]  dig [DIGITS];
      logic        neg;
      logic        zfill;
      logic [7:0]  sign_ch;
      int ndig, prec, width, n, ad, m, pad, k, j, idx;
      field_char_type c;
      case (s.length_mode)
         LEN_INT32: v = {{32{s.value[31]}}, s.value[31:0]};
         LEN_INT8:  v = {{56{s.value[7]}}, s.value[7:0]};
         LEN_INT16: v = {{48{s.value[15]}}, s.value[15:0]};
         default:   v = s.value;
      endcase
      neg = v[63];
      mag = neg ? (~v + 64'd1) : v;
      ndig = 0;
      while (mag != 64'd0) begin
         dig[ndig] = 4'(mag % 64'd10);
         mag = mag / 64'd10;
         ndig++;
      end
      prec = s.precision_given ? int'(s.precision) : 1;
      if (prec > MAX_FIELD - 1) prec = MAX_FIELD - 1;
      width = int'(s.min_width);
      if (width > MAX_FIELD) width = MAX_FIELD;
      n       = (ndig > prec) ? ndig : prec;
      ad      = (neg || s.plus_sign || s.space_sign) ? 1 : 0;
      sign_ch = neg ? CHAR_MINUS : (s.plus_sign ? CHAR_PLUS : CHAR_SPACE);
      m       = (n + ad > width) ? n + ad : width;
      pad     = m - n - ad;
      zfill   = s.zero_pad && !s.left_justify && !s.precision_given;
      if (m == 0) empty_fields++;
      for (k = 0; k < m; k++) begin
         // j is the digit position from the most significant end, -1 off the digits
         j = -1;
         if (s.left_justify) begin
            if (k < ad) c.symbol = sign_ch;
            else if (k < ad + n) j = k - ad;
            else c.symbol = CHAR_SPACE;
         end else if (zfill) begin
            if (k < ad) c.symbol = sign_ch;
            else if (k < ad + pad) c.symbol = CHAR_ZERO;
            else j = k - ad - pad;
         end else begin
            if (k < pad) c.symbol = CHAR_SPACE;
            else if (k < pad + ad) c.symbol = sign_ch;
            else j = k - pad - ad;
         end
         if (j >= 0) begin
            idx = n - 1 - j;
            c.symbol = (idx < ndig) ? CHAR_ZERO + 8'(dig[idx]) : CHAR_ZERO;
         end
         chars_emitted   = chars_emitted + 1'b1;
         c.is_last       = (k + 1 == m);
         c.running_total = chars_emitted;
         expected_chars.push_back(c);
      end
   endfunction

   // Idle rates per phase: receiver heavy first, then sender heavy, then none
   always_comb begin
      if (fields_accepted < PHASE_ONE_END) begin
         send_idle_pct = 37;
         recv_idle_pct = 61;
      end else if (fields_accepted < PHASE_TWO_END) begin
         send_idle_pct = 61;
         recv_idle_pct = 37;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   // Driver: predict accepted items, offer the next pending one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            format_field(offered_spec);
            fields_accepted <= fields_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_specs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_spec = pending_specs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0000, offered_spec.space_sign, offered_spec.plus_sign,
                              offered_spec.zero_pad, offered_spec.left_justify,
                              offered_spec.precision, offered_spec.precision_given,
                              offered_spec.min_width, offered_spec.length_mode,
                              offered_spec.value};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver backpressure, with one long hold-off to fill the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!stall_done && fields_accepted >= STALL_AT_FIELD) begin
         stall_done <= 1'b1;
         stall_left <= STALL_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: check each character against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         chars_checked++;
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%h", rsp_tdata[7:0]));
         end else begin
            oldest_char = expected_chars.pop_front();
            if (rsp_tdata[7:0] !== oldest_char.symbol)
               report_mismatch($sformatf("char 0x%h, want 0x%h (total %0d)", rsp_tdata[7:0],
                                         oldest_char.symbol, oldest_char.running_total));
            if (rsp_tlast !== oldest_char.is_last)
               report_mismatch($sformatf("tlast %b, want %b (total %0d)", rsp_tlast,
                                         oldest_char.is_last, oldest_char.running_total));
            if (rsp_tdata[8 +: TOTAL_W] !== oldest_char.running_total)
               report_mismatch($sformatf("total %0d, want %0d", rsp_tdata[8 +: TOTAL_W],
                                         oldest_char.running_total));
         end
      end
   end

   // Cycles without any accepted item on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      field_spec_type s;
      int small_val;
      // Directed: empty field, zero, extremes, length codes, layouts
      pending_specs.push_back(make_spec(64'd0, LEN_INT32, 0, 1, 0, 0, 0, 0, 0));
      pending_specs.push_back(make_spec(64'd0, LEN_INT32, 0, 0, 0, 0, 0, 0, 0));
      pending_specs.push_back(make_spec(64'h8000_0000_0000_0000, LEN_LONG, 0, 0, 0, 0, 0, 0, 0));
      pending_specs.push_back(make_spec(64'h7FFF_FFFF_FFFF_FFFF, LEN_LLONG, 0, 0, 0, 0, 0, 1, 0));
      pending_specs.push_back(make_spec(64'hFFFF_FFFF_FFFF_FFFF, LEN_SPARE, 4, 0, 0, 0, 0, 0, 0));
      pending_specs.push_back(make_spec(64'h0000_0000_0000_0080, LEN_INT8, 0, 0, 0, 0, 0, 0, 0));
      pending_specs.push_back(make_spec(64'hFFFF_FFFF_FFFF_7FFF, LEN_INT16, 0, 0, 0, 0, 0, 0, 1));
      pending_specs.push_back(make_spec(64'h0000_0001_8000_0000, LEN_INT32, 0, 0, 0, 0, 0, 0, 0));
      pending_specs.push_back(make_spec(64'd42, LEN_INT32, 63, 0, 0, 0, 0, 1, 0));
      pending_specs.push_back(make_spec(64'd1234, LEN_INT32, 20, 0, 0, 1, 0, 0, 1));
      pending_specs.push_back(make_spec(-64'd987, LEN_INT32, 15, 0, 0, 0, 1, 0, 0));
      pending_specs.push_back(make_spec(64'd77, LEN_INT32, 12, 1, 5, 0, 1, 0, 0));
      pending_specs.push_back(make_spec(-64'd77, LEN_INT32, 12, 0, 0, 1, 1, 0, 0));
      pending_specs.push_back(make_spec(-64'd5, LEN_LONG, 63, 1, 63, 0, 0, 0, 0));
      pending_specs.push_back(make_spec(64'd9, LEN_LLONG, 0, 1, 62, 0, 0, 1, 0));
      pending_specs.push_back(make_spec(64'd0, LEN_INT32, 0, 1, 0, 0, 0, 1, 0));
      pending_specs.push_back(make_spec(64'd0, LEN_INT32, 5, 1, 0, 0, 0, 0, 0));
      pending_specs.push_back(make_spec(64'd31, LEN_INT32, 0, 0, 40, 0, 0, 0, 0));
      pending_specs.push_back(make_spec(64'h8000_0000_0000_0001, 3'd5, 0, 0, 0, 0, 0, 0, 0));
      pending_specs.push_back(make_spec(64'd123, 3'd6, 8, 0, 0, 0, 1, 1, 1));
      pending_specs.push_back(make_spec(64'h0000_0000_0000_FF00, LEN_INT8, 6, 1, 3, 1, 1, 1, 1));
      pending_specs.push_back(make_spec(64'd0, LEN_INT16, 63, 0, 0, 0, 1, 0, 1));

      // Random: mixed magnitudes, mostly short fields, a few long ones
      repeat (RANDOM_FIELDS) begin
         case ($urandom_range(4))
            0: begin
               small_val = int'($urandom_range(2000)) - 1000;
               s.value = {{32{small_val[31]}}, small_val};
            end
            1: case ($urandom_range(3))
                  0: s.value = 64'h8000_0000_0000_0000;
                  1: s.value = 64'h7FFF_FFFF_FFFF_FFFF;
                  2: s.value = 64'hFFFF_FFFF_FFFF_FFFF;
                  default: s.value = 64'd0;
               endcase
            2: s.value = {$urandom, $urandom} >> $urandom_range(63);
            3: s.value = -({$urandom, $urandom} >> $urandom_range(63));
            default: s.value = {$urandom, $urandom};
         endcase
         s.length_mode     = 3'($urandom_range(7));
         s.min_width       = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                      : 6'($urandom_range(24));
         s.precision_given = 1'($urandom_range(1));
         s.precision       = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                      : 6'($urandom_range(12));
         s.left_justify    = 1'($urandom_range(1));
         s.zero_pad        = 1'($urandom_range(1));
         s.plus_sign       = 1'($urandom_range(1));
         s.space_sign      = 1'($urandom_range(1));
         pending_specs.push_back(s);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_specs.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Formatted %0d fields (%0d empty) into %0d checked characters,",
               fields_accepted, empty_fields, chars_checked);
      $display("over all length codes, flags and widths, with one long output stall.");
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", error_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
